// ----- src/sdf_pkg.sv -----
// Shared types, constants and width helpers of the shape distance block.
package sdf_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 4;

    localparam int PT_W     = 24;   // point coordinate width
    localparam int DIFF_W   = 25;   // width of b - a per axis
    localparam int DBB_W    = 49;   // width of |b - a| squared
    localparam int CORNER_W = 16;
    localparam int DIST_W   = 32;

    localparam logic [23:0] RADIUS_RST = 24'd800;
    localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        SHAPE_CIRCLE  = 2'd0,
        SHAPE_BOX     = 2'd1,
        SHAPE_RBOX    = 2'd2,
        SHAPE_SEGMENT = 2'd3
    } sdf_shape_t;

    typedef enum logic [2:0] {
        CFG_SHAPE  = 3'd0,
        CFG_AX     = 3'd1,
        CFG_AY     = 3'd2,
        CFG_BX     = 3'd3,
        CFG_BY     = 3'd4,
        CFG_RADIUS = 3'd5,
        CFG_CORNER = 3'd6
    } sdf_cfg_idx_t;

    typedef struct packed {
        logic valid;
        logic use_div;
        logic halve;
    } sdf_ctl_t;

    // Signed width that holds every coordinate difference of the datapath.
    function automatic int calc_vw(input int coord_bits, input int frac_bits);
        int pw;
        pw = coord_bits + frac_bits;
        return ((pw > PT_W) ? pw : PT_W) + 4;
    endfunction

    function automatic int calc_nw(input int coord_bits, input int frac_bits);
        return 2 * calc_vw(coord_bits, frac_bits) - 1;
    endfunction

    function automatic int calc_ow(input int coord_bits, input int frac_bits);
        return calc_vw(coord_bits, frac_bits) + 1;
    endfunction

    function automatic int calc_numw(input int coord_bits, input int frac_bits);
        return 2 * (calc_vw(coord_bits, frac_bits) + DIFF_W);
    endfunction

endpackage

// ----- src/sdf_shape_distance_top.sv -----
// Top level of the pixel-to-shape signed distance pipeline.
// One pixel transfer is taken every clock while the pipeline moves, and one distance leaves
// for each, in order. There are 3*VW + 9 register stages, VW = max(COORD_BITS+FRAC_BITS,
// 24) + 4 (93 stages at the defaults): an input register, seven geometry stages, 2*VW-1
// divider stages at one quotient bit each, VW square-root stages at one root bit each, a
// final offset and saturation stage and the output register. The output register lets a new
// pixel enter while a finished distance waits; the pipeline only holds when its last stage
// and the output register are both full and m_tready is low. Configuration writes are to be
// made only when idle; the block itself does not enforce it. Derived terms of points a and b
// settle through the dx/dy, squared and dbb registers after a write.
module sdf_shape_distance_top #(
    parameter int COORD_BITS = sdf_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sdf_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [15:0] pixel_x, [31:16] pixel_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [31:0] distance
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int PW = COORD_BITS + FRAC_BITS;
    localparam int NW = sdf_pkg::calc_nw(COORD_BITS, FRAC_BITS);
    localparam int OW = sdf_pkg::calc_ow(COORD_BITS, FRAC_BITS);
    localparam int NUMW = sdf_pkg::calc_numw(COORD_BITS, FRAC_BITS);
    // Each pixel field is 16 bits wide, so at most that many coordinate bits are used.
    localparam int IN_BITS = (COORD_BITS < 16) ? COORD_BITS : 16;

    sdf_pkg::sdf_shape_t                 shape_reg;
    logic signed [sdf_pkg::PT_W-1:0]     ax_reg, ay_reg, bx_reg, by_reg;
    logic [23:0]                         radius_reg;
    logic [63:0]                         corner_reg;
    logic signed [sdf_pkg::DIFF_W-1:0]   dx_reg, dy_reg;
    logic [sdf_pkg::DBB_W-2:0]           dxx_reg, dyy_reg;
    logic [sdf_pkg::DBB_W-1:0]           dbb_reg;
    logic [sdf_pkg::DIFF_W-2:0]          dx_mag, dy_mag;

    logic                    in_valid_reg;
    logic [PW-1:0]           px_reg, py_reg;
    logic                    out_valid_reg;
    logic [31:0]             out_data_reg;
    logic                    en, last_valid;
    logic signed [31:0]      last_dist;

    sdf_pkg::sdf_ctl_t       geom_ctl, div_ctl;
    logic [NUMW-1:0]         geom_num;
    logic [NW-1:0]           geom_alt, div_n;
    logic signed [OW-1:0]    geom_off, div_off;

    // The pipeline moves unless a finished item is blocked by a full output register.
    assign en        = !last_valid || !out_valid_reg || m_tready;
    assign s_tready  = aresetn && en;
    assign cfg_ready = aresetn;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_reg  <= sdf_pkg::SHAPE_CIRCLE;
            ax_reg     <= '0;
            ay_reg     <= '0;
            bx_reg     <= '0;
            by_reg     <= '0;
            radius_reg <= sdf_pkg::RADIUS_RST;
            corner_reg <= '0;
        end else if (cfg_valid) begin
            unique case (sdf_pkg::sdf_cfg_idx_t'(cfg_index))
                sdf_pkg::CFG_SHAPE:  shape_reg  <= sdf_pkg::sdf_shape_t'(cfg_data[1:0]);
                sdf_pkg::CFG_AX:     ax_reg     <= cfg_data[23:0];
                sdf_pkg::CFG_AY:     ay_reg     <= cfg_data[23:0];
                sdf_pkg::CFG_BX:     bx_reg     <= cfg_data[23:0];
                sdf_pkg::CFG_BY:     by_reg     <= cfg_data[23:0];
                sdf_pkg::CFG_RADIUS: radius_reg <= cfg_data[23:0];
                sdf_pkg::CFG_CORNER: corner_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        dx_mag = dx_reg[sdf_pkg::DIFF_W-1] ? (sdf_pkg::DIFF_W-1)'(-dx_reg)
                                            : (sdf_pkg::DIFF_W-1)'(dx_reg);
        dy_mag = dy_reg[sdf_pkg::DIFF_W-1] ? (sdf_pkg::DIFF_W-1)'(-dy_reg)
                                            : (sdf_pkg::DIFF_W-1)'(dy_reg);
    end

    // Segment direction and squared length follow the point registers.
    always_ff @(posedge aclk) begin
        dx_reg  <= sdf_pkg::DIFF_W'(bx_reg) - sdf_pkg::DIFF_W'(ax_reg);
        dy_reg  <= sdf_pkg::DIFF_W'(by_reg) - sdf_pkg::DIFF_W'(ay_reg);
        dxx_reg <= (sdf_pkg::DBB_W-1)'(dx_mag) * (sdf_pkg::DBB_W-1)'(dx_mag);
        dyy_reg <= (sdf_pkg::DBB_W-1)'(dy_mag) * (sdf_pkg::DBB_W-1)'(dy_mag);
        dbb_reg <= sdf_pkg::DBB_W'(dxx_reg) + sdf_pkg::DBB_W'(dyy_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg <= PW'(s_tdata[IN_BITS-1:0]) << FRAC_BITS;
            py_reg <= PW'(s_tdata[16 +: IN_BITS]) << FRAC_BITS;
        end
    end

    // A waiting distance stays until its transfer, even while bubbles move up behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en && last_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && last_valid) begin
            out_data_reg <= last_dist;
        end
    end

    sdf_geom #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_geom (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (in_valid_reg),
        .px           (px_reg),
        .py           (py_reg),
        .shape        (shape_reg),
        .ax           (ax_reg),
        .ay           (ay_reg),
        .bx           (bx_reg),
        .by           (by_reg),
        .dx           (dx_reg),
        .dy           (dy_reg),
        .dbb          (dbb_reg),
        .radius       (radius_reg),
        .corner_radii (corner_reg),
        .ctl_out      (geom_ctl),
        .num_out      (geom_num),
        .alt_out      (geom_alt),
        .off_out      (geom_off)
    );

    sdf_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .ctl_in  (geom_ctl),
        .num_in  (geom_num),
        .alt_in  (geom_alt),
        .off_in  (geom_off),
        .dbb     (dbb_reg),
        .ctl_out (div_ctl),
        .n_out   (div_n),
        .off_out (div_off)
    );

    sdf_sqrt #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .ctl_in    (div_ctl),
        .n_in      (div_n),
        .off_in    (div_off),
        .valid_out (last_valid),
        .dist_out  (last_dist)
    );

endmodule

// ----- src/sdf_geom.sv -----
// Geometry front end: offsets, box folding, squares, dot products and the squared cross product.
module sdf_geom #(
    parameter int COORD_BITS = sdf_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sdf_pkg::FRAC_BITS_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        en,
    input  logic                                        in_valid,
    input  logic [COORD_BITS+FRAC_BITS-1:0]             px,
    input  logic [COORD_BITS+FRAC_BITS-1:0]             py,
    input  sdf_pkg::sdf_shape_t                         shape,
    input  logic signed [sdf_pkg::PT_W-1:0]             ax,
    input  logic signed [sdf_pkg::PT_W-1:0]             ay,
    input  logic signed [sdf_pkg::PT_W-1:0]             bx,
    input  logic signed [sdf_pkg::PT_W-1:0]             by,
    input  logic signed [sdf_pkg::DIFF_W-1:0]           dx,
    input  logic signed [sdf_pkg::DIFF_W-1:0]           dy,
    input  logic [sdf_pkg::DBB_W-1:0]                   dbb,
    input  logic [23:0]                                 radius,
    input  logic [63:0]                                 corner_radii,
    output sdf_pkg::sdf_ctl_t                           ctl_out,
    output logic [sdf_pkg::calc_numw(COORD_BITS, FRAC_BITS)-1:0] num_out,
    output logic [sdf_pkg::calc_nw(COORD_BITS, FRAC_BITS)-1:0]   alt_out,
    output logic signed [sdf_pkg::calc_ow(COORD_BITS, FRAC_BITS)-1:0] off_out
);

    localparam int PW   = COORD_BITS + FRAC_BITS;
    localparam int VW   = sdf_pkg::calc_vw(COORD_BITS, FRAC_BITS);
    localparam int NW   = sdf_pkg::calc_nw(COORD_BITS, FRAC_BITS);
    localparam int OW   = sdf_pkg::calc_ow(COORD_BITS, FRAC_BITS);
    localparam int SQW  = 2 * VW - 2;
    localparam int MW   = VW + sdf_pkg::DIFF_W;
    localparam int PRW  = MW + 1;
    localparam int CW   = MW;
    localparam int CL   = (CW + 1) / 2;
    localparam int CH   = CW - CL;
    localparam int NUMW = sdf_pkg::calc_numw(COORD_BITS, FRAC_BITS);

    function automatic logic [VW-2:0] mag_v(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] n;
        n = v[VW-1] ? -v : v;
        return n[VW-2:0];
    endfunction

    // Stage 1
    logic                    v1_reg;
    sdf_pkg::sdf_shape_t     sh1_reg;
    logic signed [VW-1:0]    pax1_reg, pay1_reg, p2x1_reg, p2y1_reg;
    // Stage 2
    logic                    v2_reg;
    sdf_pkg::sdf_shape_t     sh2_reg;
    logic signed [VW-1:0]    pax2_reg, pay2_reg, qx2_reg, qy2_reg;
    logic [VW-2:0]           ux2_reg, uy2_reg, pbx2_reg, pby2_reg;
    logic [16:0]             r2_2_reg;
    // Stage 3
    logic                    v3_reg, h3_reg;
    sdf_pkg::sdf_shape_t     sh3_reg;
    logic [SQW-1:0]          squ3_reg, sqv3_reg, sqbx3_reg, sqby3_reg;
    logic signed [MW-1:0]    m1_3_reg, m2_3_reg, m3_3_reg, m4_3_reg;
    logic signed [OW-1:0]    off3_reg;
    // Stage 4
    logic                    v4_reg, h4_reg;
    sdf_pkg::sdf_shape_t     sh4_reg;
    logic [NW-1:0]           na4_reg, nb4_reg;
    logic signed [PRW-1:0]   dpb4_reg, cross4_reg;
    logic signed [OW-1:0]    off4_reg;
    // Stage 5
    logic                    v5_reg, h5_reg, ud5_reg;
    logic [NW-1:0]           alt5_reg;
    logic [CW-1:0]           c5_reg;
    logic signed [OW-1:0]    off5_reg;
    // Stage 6
    logic                    v6_reg, h6_reg, ud6_reg;
    logic [NW-1:0]           alt6_reg;
    logic signed [OW-1:0]    off6_reg;
    logic [2*CL-1:0]         ll6_reg;
    logic [CL+CH-1:0]        lh6_reg;
    logic [2*CH-1:0]         hh6_reg;
    // Stage 7
    logic                    v7_reg, h7_reg, ud7_reg;
    logic [NW-1:0]           alt7_reg;
    logic signed [OW-1:0]    off7_reg;
    logic [NUMW-1:0]         num7_reg;

    // Stage 1 combinational values
    logic signed [VW-1:0]    pxs, pys, pax_next, pay_next, p2x_next, p2y_next;
    // Stage 2 combinational values
    logic [1:0]              quad;
    logic [16:0]             r2_next;
    logic signed [VW-1:0]    r2s, qx_next, qy_next, pbx_s, pby_s;
    logic [VW-2:0]           ux_next, uy_next;
    logic                    is_box1;
    // Stage 3, 5 and 6 combinational values
    logic signed [VW-1:0]    mx;
    logic signed [OW-1:0]    off_next;
    logic signed [PRW-1:0]   dbb_s, cross_abs;
    logic                    ud_next;
    logic [NW-1:0]           alt_next;
    logic [CL-1:0]           c_lo;
    logic [CH-1:0]           c_hi;

    always_comb begin
        pxs      = VW'($signed({1'b0, px}));
        pys      = VW'($signed({1'b0, py}));
        pax_next = pxs - VW'(ax);
        pay_next = pys - VW'(ay);
        p2x_next = (pxs <<< 1) - (VW'(ax) + VW'(bx));
        p2y_next = (pys <<< 1) - (VW'(ay) + VW'(by));
    end

    always_comb begin
        is_box1 = (sh1_reg == sdf_pkg::SHAPE_BOX) || (sh1_reg == sdf_pkg::SHAPE_RBOX);
        quad    = {!(p2x1_reg > 0), !(p2y1_reg > 0)};
        r2_next = (sh1_reg == sdf_pkg::SHAPE_RBOX)
                  ? {corner_radii[16*quad +: sdf_pkg::CORNER_W], 1'b0} : 17'd0;
        r2s     = VW'($signed({1'b0, r2_next}));
        qx_next = $signed({1'b0, mag_v(p2x1_reg)}) - VW'(dx) + r2s;
        qy_next = $signed({1'b0, mag_v(p2y1_reg)}) - VW'(dy) + r2s;
        if (is_box1) begin
            ux_next = (qx_next > 0) ? qx_next[VW-2:0] : '0;
            uy_next = (qy_next > 0) ? qy_next[VW-2:0] : '0;
        end else begin
            ux_next = mag_v(pax1_reg);
            uy_next = mag_v(pay1_reg);
        end
        pbx_s = pax1_reg - VW'(dx);
        pby_s = pay1_reg - VW'(dy);
    end

    always_comb begin
        mx = (qx2_reg > qy2_reg) ? qx2_reg : qy2_reg;
        case (sh2_reg)
            sdf_pkg::SHAPE_CIRCLE:  off_next = -OW'($signed({1'b0, radius}));
            sdf_pkg::SHAPE_SEGMENT: off_next = '0;
            default: off_next = ((mx < 0) ? OW'(mx) : OW'(0))
                                - OW'($signed({1'b0, r2_2_reg}));
        endcase
    end

    always_comb begin
        dbb_s     = PRW'($signed({1'b0, dbb}));
        cross_abs = cross4_reg[PRW-1] ? -cross4_reg : cross4_reg;
        ud_next   = (sh4_reg == sdf_pkg::SHAPE_SEGMENT) && (dpb4_reg > 0) && (dpb4_reg < dbb_s);
        alt_next  = ((sh4_reg == sdf_pkg::SHAPE_SEGMENT) && (dpb4_reg > 0)) ? nb4_reg : na4_reg;
        c_lo      = c5_reg[CL-1:0];
        c_hi      = c5_reg[CW-1:CL];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sh1_reg  <= shape;
            pax1_reg <= pax_next;
            pay1_reg <= pay_next;
            p2x1_reg <= p2x_next;
            p2y1_reg <= p2y_next;

            sh2_reg  <= sh1_reg;
            pax2_reg <= pax1_reg;
            pay2_reg <= pay1_reg;
            qx2_reg  <= qx_next;
            qy2_reg  <= qy_next;
            ux2_reg  <= ux_next;
            uy2_reg  <= uy_next;
            pbx2_reg <= mag_v(pbx_s);
            pby2_reg <= mag_v(pby_s);
            r2_2_reg <= r2_next;

            sh3_reg   <= sh2_reg;
            h3_reg    <= (sh2_reg == sdf_pkg::SHAPE_BOX) || (sh2_reg == sdf_pkg::SHAPE_RBOX);
            squ3_reg  <= SQW'(ux2_reg) * SQW'(ux2_reg);
            sqv3_reg  <= SQW'(uy2_reg) * SQW'(uy2_reg);
            sqbx3_reg <= SQW'(pbx2_reg) * SQW'(pbx2_reg);
            sqby3_reg <= SQW'(pby2_reg) * SQW'(pby2_reg);
            m1_3_reg  <= MW'(pax2_reg) * MW'(dx);
            m2_3_reg  <= MW'(pay2_reg) * MW'(dy);
            m3_3_reg  <= MW'(pax2_reg) * MW'(dy);
            m4_3_reg  <= MW'(pay2_reg) * MW'(dx);
            off3_reg  <= off_next;

            sh4_reg    <= sh3_reg;
            h4_reg     <= h3_reg;
            na4_reg    <= NW'(squ3_reg) + NW'(sqv3_reg);
            nb4_reg    <= NW'(sqbx3_reg) + NW'(sqby3_reg);
            dpb4_reg   <= PRW'(m1_3_reg) + PRW'(m2_3_reg);
            cross4_reg <= PRW'(m3_3_reg) - PRW'(m4_3_reg);
            off4_reg   <= off3_reg;

            h5_reg   <= h4_reg;
            ud5_reg  <= ud_next;
            alt5_reg <= alt_next;
            c5_reg   <= cross_abs[CW-1:0];
            off5_reg <= off4_reg;

            h6_reg   <= h5_reg;
            ud6_reg  <= ud5_reg;
            alt6_reg <= alt5_reg;
            off6_reg <= off5_reg;
            ll6_reg  <= (2*CL)'(c_lo) * (2*CL)'(c_lo);
            lh6_reg  <= (CL+CH)'(c_lo) * (CL+CH)'(c_hi);
            hh6_reg  <= (2*CH)'(c_hi) * (2*CH)'(c_hi);

            h7_reg   <= h6_reg;
            ud7_reg  <= ud6_reg;
            alt7_reg <= alt6_reg;
            off7_reg <= off6_reg;
            num7_reg <= (NUMW'(hh6_reg) << (2*CL)) + (NUMW'(lh6_reg) << (CL+1))
                        + NUMW'(ll6_reg);
        end
    end

    assign ctl_out = '{valid: v7_reg, use_div: ud7_reg, halve: h7_reg};
    assign num_out = num7_reg;
    assign alt_out = alt7_reg;
    assign off_out = off7_reg;

endmodule

// ----- src/sdf_div.sv -----
// Pipelined restoring divider: squared cross product over squared segment length, one bit a stage.
module sdf_div #(
    parameter int COORD_BITS = sdf_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sdf_pkg::FRAC_BITS_DEF
) (
    input  logic                                                  aclk,
    input  logic                                                  aresetn,
    input  logic                                                  en,
    input  sdf_pkg::sdf_ctl_t                                     ctl_in,
    input  logic [sdf_pkg::calc_numw(COORD_BITS, FRAC_BITS)-1:0]  num_in,
    input  logic [sdf_pkg::calc_nw(COORD_BITS, FRAC_BITS)-1:0]    alt_in,
    input  logic signed [sdf_pkg::calc_ow(COORD_BITS, FRAC_BITS)-1:0] off_in,
    input  logic [sdf_pkg::DBB_W-1:0]                             dbb,
    output sdf_pkg::sdf_ctl_t                                     ctl_out,
    output logic [sdf_pkg::calc_nw(COORD_BITS, FRAC_BITS)-1:0]    n_out,
    output logic signed [sdf_pkg::calc_ow(COORD_BITS, FRAC_BITS)-1:0] off_out
);

    localparam int NW = sdf_pkg::calc_nw(COORD_BITS, FRAC_BITS);
    localparam int OW = sdf_pkg::calc_ow(COORD_BITS, FRAC_BITS);
    localparam int QB = NW;              // the quotient of interest fits the root input
    localparam int RW = sdf_pkg::DBB_W;  // remainder stays below the divisor

    logic                 v_reg   [QB];
    logic                 ud_reg  [QB];
    logic                 h_reg   [QB];
    logic [RW-1:0]        rem_reg [QB];
    logic [QB-1:0]        lq_reg  [QB];
    logic [NW-1:0]        alt_reg [QB];
    logic signed [OW-1:0] off_reg [QB];

    for (genvar g = 0; g < QB; g++) begin : g_step
        logic                 v_in, ud_in, h_in, ge;
        logic [RW-1:0]        rem_in, rem_next;
        logic [QB-1:0]        lq_in;
        logic [NW-1:0]        alt_g;
        logic signed [OW-1:0] off_g;
        logic [RW:0]          trial;

        if (g == 0) begin : g_first
            assign v_in   = ctl_in.valid;
            assign ud_in  = ctl_in.use_div;
            assign h_in   = ctl_in.halve;
            assign rem_in = num_in[QB +: RW];
            assign lq_in  = num_in[QB-1:0];
            assign alt_g  = alt_in;
            assign off_g  = off_in;
        end else begin : g_later
            assign v_in   = v_reg[g-1];
            assign ud_in  = ud_reg[g-1];
            assign h_in   = h_reg[g-1];
            assign rem_in = rem_reg[g-1];
            assign lq_in  = lq_reg[g-1];
            assign alt_g  = alt_reg[g-1];
            assign off_g  = off_reg[g-1];
        end

        // Low numerator bits shift out the top while quotient bits shift in below.
        assign trial    = {rem_in, lq_in[QB-1]};
        assign ge       = trial >= {1'b0, dbb};
        assign rem_next = ge ? RW'(trial - {1'b0, dbb}) : trial[RW-1:0];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en) begin
                v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ud_reg[g]  <= ud_in;
                h_reg[g]   <= h_in;
                rem_reg[g] <= rem_next;
                lq_reg[g]  <= {lq_in[QB-2:0], ge};
                alt_reg[g] <= alt_g;
                off_reg[g] <= off_g;
            end
        end
    end

    assign ctl_out = '{valid: v_reg[QB-1], use_div: ud_reg[QB-1], halve: h_reg[QB-1]};
    assign n_out   = ud_reg[QB-1] ? lq_reg[QB-1] : alt_reg[QB-1];
    assign off_out = off_reg[QB-1];

endmodule

// ----- src/sdf_sqrt.sv -----
// Pipelined integer square root, one root bit a stage, followed by offset, halving and saturation.
module sdf_sqrt #(
    parameter int COORD_BITS = sdf_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sdf_pkg::FRAC_BITS_DEF
) (
    input  logic                                                  aclk,
    input  logic                                                  aresetn,
    input  logic                                                  en,
    input  sdf_pkg::sdf_ctl_t                                     ctl_in,
    input  logic [sdf_pkg::calc_nw(COORD_BITS, FRAC_BITS)-1:0]    n_in,
    input  logic signed [sdf_pkg::calc_ow(COORD_BITS, FRAC_BITS)-1:0] off_in,
    output logic                                                  valid_out,
    output logic signed [sdf_pkg::DIST_W-1:0]                     dist_out
);

    localparam int NW  = sdf_pkg::calc_nw(COORD_BITS, FRAC_BITS);
    localparam int OW  = sdf_pkg::calc_ow(COORD_BITS, FRAC_BITS);
    localparam int SB  = sdf_pkg::calc_vw(COORD_BITS, FRAC_BITS);
    localparam int NPW = 2 * SB;
    localparam int SMW = SB + 2;
    localparam int XW  = SMW + sdf_pkg::DIST_W;

    logic                 v_reg   [SB];
    logic                 h_reg   [SB];
    logic [SB:0]          rs_reg  [SB];
    logic [SB-1:0]        rt_reg  [SB];
    logic [NPW-1:0]       ns_reg  [SB];
    logic signed [OW-1:0] off_reg [SB];

    for (genvar g = 0; g < SB; g++) begin : g_step
        logic                 v_in, h_in, ge;
        logic [SB:0]          rem_in;
        logic [SB-1:0]        root_in;
        logic [NPW-1:0]       ns_in;
        logic signed [OW-1:0] off_g;
        logic [SB+1:0]        t, trial;

        if (g == 0) begin : g_first
            assign v_in    = ctl_in.valid;
            assign h_in    = ctl_in.halve;
            assign rem_in  = '0;
            assign root_in = '0;
            assign ns_in   = {1'b0, n_in};
            assign off_g   = off_in;
        end else begin : g_later
            assign v_in    = v_reg[g-1];
            assign h_in    = h_reg[g-1];
            assign rem_in  = rs_reg[g-1];
            assign root_in = rt_reg[g-1];
            assign ns_in   = ns_reg[g-1];
            assign off_g   = off_reg[g-1];
        end

        assign t     = {rem_in[SB-1:0], ns_in[NPW-1 -: 2]};
        assign trial = {root_in, 2'b01};
        assign ge    = t >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en) begin
                v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                h_reg[g]   <= h_in;
                rs_reg[g]  <= ge ? (SB+1)'(t - trial) : t[SB:0];
                rt_reg[g]  <= {root_in[SB-2:0], ge};
                ns_reg[g]  <= {ns_in[NPW-3:0], 2'b00};
                off_reg[g] <= off_g;
            end
        end
    end

    logic                              vo_reg;
    logic signed [sdf_pkg::DIST_W-1:0] dist_reg, dist_next;
    logic signed [SMW-1:0]             sum, halved;
    logic signed [XW-1:0]              ext;

    always_comb begin
        sum    = SMW'($signed({1'b0, rt_reg[SB-1]})) + SMW'(off_reg[SB-1]);
        // Arithmetic shift gives the halving that rounds toward minus infinity.
        halved = h_reg[SB-1] ? (sum >>> 1) : sum;
        ext    = XW'(halved);
        if (ext > XW'(sdf_pkg::DIST_MAX)) begin
            dist_next = sdf_pkg::DIST_MAX;
        end else if (ext < XW'(sdf_pkg::DIST_MIN)) begin
            dist_next = sdf_pkg::DIST_MIN;
        end else begin
            dist_next = ext[sdf_pkg::DIST_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (en) begin
            vo_reg <= v_reg[SB-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dist_reg <= dist_next;
        end
    end

    assign valid_out = vo_reg;
    assign dist_out  = dist_reg;

endmodule

// ----- src/sdf_check.sv -----
// Port-level checks of the shape distance block, bound to its top level.
module sdf_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A reset leaves no result on the output.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result transfer keeps its data.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A consumer that takes results never blocks the input side.
    a_ready_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output is taken");

    // An empty output register always lets the pipeline advance.
    a_empty_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind sdf_shape_distance_top sdf_check u_sdf_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
